// ===== hdl/turtle_vector_generator_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef TURTLE_VECTOR_GENERATOR_MACROS_SVH
`define TURTLE_VECTOR_GENERATOR_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent.
`define TVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define TVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tvg_pkg.sv =====
package tvg_pkg;

  // Core sizes.
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 8;
  localparam int COORD_W      = 24;
  localparam int COLOR_W      = 24;
  localparam int ANGLE_W      = 17;
  localparam int HEAD_W       = 16;
  localparam int HACC_W       = 18;
  localparam int REM_W        = 14;
  localparam int TRIG_W       = 32;
  localparam int PROD_W       = COORD_W + TRIG_W;
  localparam int SUM_W        = COORD_W + 3;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CFG_IDX_W    = 2;

  // Heading units are 1/128 degree.
  localparam int FULL_TURN    = 46080;
  localparam int QUARTER_TURN = 11520;
  localparam int RECT_WRAP    = FULL_TURN - QUARTER_TURN;

  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));
  localparam logic signed [COORD_W-1:0] HOME_RESET = COORD_W'(200 << FRAC_BITS);

  // CORDIC gain 0.6072529 in Q2.30, and the rounding term for Q2.30 products.
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
  localparam logic signed [PROD_W-1:0] ROUND_HALF  = PROD_W'(1 << 29);
  localparam int TRIG_FRAC = 30;

  typedef enum logic [1:0] {
    MODE_FORWARD,
    MODE_LINE,
    MODE_RECT,
    MODE_TURN
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEN_UP,
    CFG_PEN_COLOR,
    CFG_HOME_X,
    CFG_HOME_Y
  } cfg_idx_t;

  // Request to the shared trig unit: quadrant and remainder of the heading.
  typedef struct packed {
    logic             start;
    logic [1:0]       quad;
    logic [REM_W-1:0] rem;
  } cordic_req_t;

  // Result: cosine and sine in Q2.30, valid from the done pulse on.
  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } cordic_rsp_t;

  // atan(2^-i) in units of 2^-23 degree.
  function automatic logic signed [TRIG_W-1:0] atan_entry(input int idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      0:  v = TRIG_W'(377487360);
      1:  v = TRIG_W'(222843801);
      2:  v = TRIG_W'(117744544);
      3:  v = TRIG_W'(59768969);
      4:  v = TRIG_W'(30000467);
      5:  v = TRIG_W'(15014858);
      6:  v = TRIG_W'(7509261);
      7:  v = TRIG_W'(3754860);
      8:  v = TRIG_W'(1877459);
      9:  v = TRIG_W'(938733);
      10: v = TRIG_W'(469367);
      11: v = TRIG_W'(234684);
      12: v = TRIG_W'(117342);
      13: v = TRIG_W'(58671);
      14: v = TRIG_W'(29335);
      15: v = TRIG_W'(14668);
      16: v = TRIG_W'(7334);
      17: v = TRIG_W'(3667);
      18: v = TRIG_W'(1833);
      19: v = TRIG_W'(917);
      20: v = TRIG_W'(458);
      21: v = TRIG_W'(229);
      22: v = TRIG_W'(115);
      23: v = TRIG_W'(57);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp a widened coordinate to the signed coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SUM_W'(COORD_MAX)) begin
      r = COORD_W'(COORD_MAX);
    end else if (v < SUM_W'(COORD_MIN)) begin
      r = COORD_W'(COORD_MIN);
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/tvg_cmd_if.sv =====
interface tvg_cmd_if;
  import tvg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic signed [COORD_W-1:0] distance;
  logic signed [COORD_W-1:0] side_b;
  logic signed [ANGLE_W-1:0] turn_angle;

  modport source (output valid, mode, distance, side_b, turn_angle, input ready);
  modport sink (input valid, mode, distance, side_b, turn_angle, output ready);
endinterface

// ===== hdl/tvg_seg_if.sv =====
interface tvg_seg_if;
  import tvg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0]        seg_color;
  logic                      last_segment;

  modport source (output valid, start_x, start_y, end_x, end_y, seg_color, last_segment,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, seg_color, last_segment,
                output ready);
endinterface

// ===== hdl/tvg_cfg_if.sv =====
interface tvg_cfg_if;
  import tvg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/turtle_vector_generator.sv =====
// Turtle graphics vector generator.
// Commands arrive on in_cmd (forward, line, rectangle, turn); each drawn line
// leaves on out_seg as one item with start and end points in Q15.8, the pen
// color and a flag on the last segment of the command. cfg_wr writes pen_up,
// pen_color, home_x and home_y; it is always ready, and a home write also moves
// the pen. Write configuration only while no command is in flight.
// A turn, or a line or rectangle with the pen up, only passes through the heading
// wrap step before the next command can be taken. For each segment the quadrant
// is found by repeated subtraction, then the shared CORDIC unit iterates 16
// times, then one multiplier forms the x and y offsets in turn. A forward with
// the pen up draws nothing and moves the pen without the emit step. A rectangle
// costs four such passes. in_cmd.ready is low for the whole command. A segment
// waits in the output register while the receiver stalls; the block stops
// before loading the next segment until it is taken.
// Synchronous reset puts the pen at 200.0, 200.0 with heading zero, pen down,
// color black, and empties the output register.
module turtle_vector_generator (
  input logic       clk,
  input logic       rst_n,
  tvg_cmd_if.sink   in_cmd,
  tvg_seg_if.source out_seg,
  tvg_cfg_if.sink   cfg_wr
);
  import tvg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WRAP, S_QUAD, S_TRIG, S_MULC, S_MULS, S_ENDY, S_EMIT
  } state_t;

  state_t                    state_r;
  mode_t                     mode_r;
  logic signed [COORD_W-1:0] dist_r;
  logic signed [COORD_W-1:0] side_r;
  logic [1:0]                seg_idx_r;
  logic signed [HACC_W-1:0]  head_acc_r;
  logic [HEAD_W-1:0]         heading_r;
  logic [HEAD_W-1:0]         rem_r;
  logic [1:0]                quad_r;
  logic                      cordic_start_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [COORD_W-1:0] ex_r;
  logic signed [COORD_W-1:0] ey_r;
  logic signed [COORD_W-1:0] pos_x_r;
  logic signed [COORD_W-1:0] pos_y_r;
  logic                      pen_up_r;
  logic [COLOR_W-1:0]        pen_color_r;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_sx_r;
  logic signed [COORD_W-1:0] out_sy_r;
  logic signed [COORD_W-1:0] out_ex_r;
  logic signed [COORD_W-1:0] out_ey_r;
  logic [COLOR_W-1:0]        out_color_r;
  logic                      out_last_r;

  cordic_req_t               cordic_req;
  cordic_rsp_t               cordic_rsp;

  logic signed [HACC_W-1:0]  head_sum;
  logic signed [COORD_W-1:0] len;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [PROD_W-TRIG_FRAC-1:0] offset;
  logic signed [COORD_W-1:0] ex_nxt;
  logic signed [COORD_W-1:0] ey_nxt;
  logic [HEAD_W-1:0]         rect_head_nxt;
  logic                      emit_go;
  logic                      last_seg;
  mode_t                     in_mode;

  // Shared trig unit.
  assign cordic_req.start = cordic_start_r;
  assign cordic_req.quad  = quad_r;
  assign cordic_req.rem   = rem_r[REM_W-1:0];

  tvg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .rsp   (cordic_rsp)
  );

  // Heading arithmetic.
  assign in_mode  = mode_t'(in_cmd.mode);
  assign head_sum = signed'({2'b00, heading_r}) + HACC_W'(in_cmd.turn_angle);
  assign rect_head_nxt = (heading_r >= HEAD_W'(RECT_WRAP)) ?
                         heading_r - HEAD_W'(RECT_WRAP) :
                         heading_r + HEAD_W'(QUARTER_TURN);

  // Odd rectangle sides use the second length.
  assign len = seg_idx_r[0] ? side_r : dist_r;

  // Round the Q2.30 product half up and add it to the pen position.
  assign rounded = prod_r + ROUND_HALF;
  assign offset  = rounded[PROD_W-1:TRIG_FRAC];
  assign ex_nxt  = sat_coord(SUM_W'(pos_x_r) + SUM_W'(offset));
  assign ey_nxt  = sat_coord(SUM_W'(pos_y_r) + SUM_W'(offset));

  // A segment is loaded once the output register is free or being taken.
  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || out_seg.ready);
  assign last_seg = (mode_r != MODE_RECT) || (seg_idx_r == 2'd3);

  // Command sequencer, pen state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cordic_start_r <= 1'b0;
      out_valid_r    <= 1'b0;
      pen_up_r       <= 1'b0;
      pen_color_r    <= '0;
      pos_x_r        <= HOME_RESET;
      pos_y_r        <= HOME_RESET;
      heading_r      <= '0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
        out_sx_r    <= pos_x_r;
        out_sy_r    <= pos_y_r;
        out_ex_r    <= ex_r;
        out_ey_r    <= ey_r;
        out_color_r <= pen_color_r;
        out_last_r  <= last_seg;
      end else if (out_seg.ready) begin
        out_valid_r <= 1'b0;
      end

      // Register writes; these must only be issued while no command is in flight, which the block does not enforce.
      if (cfg_wr.valid) begin
        unique case (cfg_idx_t'(cfg_wr.index))
          CFG_PEN_UP:    pen_up_r    <= cfg_wr.data[0];
          CFG_PEN_COLOR: pen_color_r <= cfg_wr.data[COLOR_W-1:0];
          CFG_HOME_X:    pos_x_r     <= signed'(cfg_wr.data);
          CFG_HOME_Y:    pos_y_r     <= signed'(cfg_wr.data);
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_cmd.valid) begin
            mode_r    <= in_mode;
            dist_r    <= in_cmd.distance;
            side_r    <= in_cmd.side_b;
            seg_idx_r <= '0;
            if (in_mode == MODE_TURN) begin
              head_acc_r <= head_sum;
              state_r    <= S_WRAP;
            end else if (pen_up_r && in_mode != MODE_FORWARD) begin
              // Nothing to draw: pass through the wrap step unchanged.
              head_acc_r <= signed'({2'b00, heading_r});
              state_r    <= S_WRAP;
            end else begin
              rem_r   <= heading_r;
              quad_r  <= '0;
              state_r <= S_QUAD;
            end
          end
        end
        S_WRAP: begin
          // Bring the heading back into one full turn, one correction a cycle.
          if (head_acc_r < 0) begin
            head_acc_r <= head_acc_r + HACC_W'(FULL_TURN);
          end else if (head_acc_r >= HACC_W'(FULL_TURN)) begin
            head_acc_r <= head_acc_r - HACC_W'(FULL_TURN);
          end else begin
            heading_r <= head_acc_r[HEAD_W-1:0];
            state_r   <= S_IDLE;
          end
        end
        S_QUAD: begin
          // Split the heading into quadrant and remainder.
          if (rem_r >= HEAD_W'(QUARTER_TURN)) begin
            rem_r  <= rem_r - HEAD_W'(QUARTER_TURN);
            quad_r <= quad_r + 2'd1;
          end else begin
            cordic_start_r <= 1'b1;
            state_r        <= S_TRIG;
          end
        end
        S_TRIG: begin
          cordic_start_r <= 1'b0;
          if (cordic_rsp.done) begin
            state_r <= S_MULC;
          end
        end
        S_MULC: begin
          prod_r  <= len * cordic_rsp.cos_v;
          state_r <= S_MULS;
        end
        S_MULS: begin
          prod_r  <= len * cordic_rsp.sin_v;
          ex_r    <= ex_nxt;
          state_r <= S_ENDY;
        end
        S_ENDY: begin
          ey_r <= ey_nxt;
          if (mode_r == MODE_FORWARD && pen_up_r) begin
            // Pen up: move without drawing.
            pos_x_r <= ex_r;
            pos_y_r <= ey_nxt;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (mode_r != MODE_LINE) begin
              pos_x_r <= ex_r;
              pos_y_r <= ey_r;
            end
            if (mode_r == MODE_RECT) begin
              heading_r <= rect_head_nxt;
              seg_idx_r <= seg_idx_r + 2'd1;
              if (seg_idx_r == 2'd3) begin
                state_r <= S_IDLE;
              end else begin
                rem_r   <= rect_head_nxt;
                quad_r  <= '0;
                state_r <= S_QUAD;
              end
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_cmd.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;

  assign out_seg.valid        = out_valid_r;
  assign out_seg.start_x      = out_sx_r;
  assign out_seg.start_y      = out_sy_r;
  assign out_seg.end_x        = out_ex_r;
  assign out_seg.end_y        = out_ey_r;
  assign out_seg.seg_color    = out_color_r;
  assign out_seg.last_segment = out_last_r;

endmodule

// ===== hdl/tvg_cordic.sv =====
module tvg_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  tvg_pkg::cordic_req_t req,
  output tvg_pkg::cordic_rsp_t rsp
);
  import tvg_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ROT} cstate_t;

  cstate_t                  state_r;
  logic [STEP_W-1:0]        step_r;
  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] x_r;
  logic signed [TRIG_W-1:0] y_r;
  logic signed [TRIG_W-1:0] z_r;
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;
  logic                     done_r;

  logic signed [TRIG_W-1:0] xs;
  logic signed [TRIG_W-1:0] ys;
  logic signed [TRIG_W-1:0] angle;

  // One rotation step: arithmetic shifts by the step index and the table angle.
  assign xs    = x_r >>> step_r;
  assign ys    = y_r >>> step_r;
  assign angle = atan_entry(int'(step_r));

  // Sequencer for the iterations and the final quadrant rotation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            x_r     <= CORDIC_GAIN;
            y_r     <= '0;
            z_r     <= TRIG_W'({req.rem, 16'b0});
            step_r  <= '0;
            quad_r  <= req.quad;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z_r[TRIG_W-1]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - angle;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + angle;
          end
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
            state_r <= C_ROT;
          end
        end
        C_ROT: begin
          // Rotate the first-quadrant result by whole quarter turns.
          case (quad_r)
            2'd0: begin
              cos_r <= x_r;
              sin_r <= y_r;
            end
            2'd1: begin
              cos_r <= -y_r;
              sin_r <= x_r;
            end
            2'd2: begin
              cos_r <= -x_r;
              sin_r <= -y_r;
            end
            default: begin
              cos_r <= y_r;
              sin_r <= -x_r;
            end
          endcase
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = cos_r;
  assign rsp.sin_v = sin_r;

endmodule

// ===== hdl/tvg_checker.sv =====
`include "turtle_vector_generator_macros.svh"

module tvg_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [tvg_pkg::COORD_W-1:0] out_start_x,
  input logic signed [tvg_pkg::COORD_W-1:0] out_start_y,
  input logic signed [tvg_pkg::COORD_W-1:0] out_end_x,
  input logic signed [tvg_pkg::COORD_W-1:0] out_end_y,
  input logic [tvg_pkg::COLOR_W-1:0]        out_seg_color,
  input logic                               out_last_segment
);
  import tvg_pkg::*;

  // A command keeps the block busy for at least the cycle after acceptance.
  `TVG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // A new segment is only ever loaded while a command is in flight.
  `TVG_ASSERT_NOW(a_seg_while_busy, $rose(out_valid), !$past(in_ready), "segment while idle")

  // Taking a segment that is not the last one leaves the command still running.
  `TVG_ASSERT_NOW(a_rect_busy, out_valid && out_ready && !out_last_segment, !in_ready, "idle mid-command")

  // A stalled segment holds its contents.
  `TVG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_start_x) && $stable(out_start_y) && $stable(out_end_x) && $stable(out_end_y) && $stable(out_seg_color) && $stable(out_last_segment), "stalled segment changed")

endmodule

bind turtle_vector_generator tvg_checker u_tvg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_cmd.valid),
  .in_ready         (in_cmd.ready),
  .out_valid        (out_seg.valid),
  .out_ready        (out_seg.ready),
  .out_start_x      (out_seg.start_x),
  .out_start_y      (out_seg.start_y),
  .out_end_x        (out_seg.end_x),
  .out_end_y        (out_seg.end_y),
  .out_seg_color    (out_seg.seg_color),
  .out_last_segment (out_seg.last_segment)
);
